FILE: sv/nsc_pkg.sv
// ----------------------------------------------------------------------
// NFA subset construction package
// Shared widths, codes, state type, control structs and clamp helpers.
// ----------------------------------------------------------------------
package nsc_pkg;

   localparam int MAX_NFA_STATES  = 8;
   localparam int MAX_SYMBOLS     = 4;
   localparam int MAX_DFA_ROWS    = 256;

   localparam int STATE_W         = 3;
   localparam int SYM_W           = 2;
   localparam int ROW_W           = 8;
   localparam int COUNT_W         = 9;
   localparam int MASK_W          = 8;
   localparam int NFA_TABLE_DEPTH = MAX_NFA_STATES * MAX_SYMBOLS;
   localparam int NFA_ADDR_W      = STATE_W + SYM_W;
   localparam int NEXT_ADDR_W     = ROW_W + SYM_W;
   localparam int CSR_INDEX_W     = 2;
   localparam int CSR_DATA_W      = 8;

   localparam logic [1:0] MODE_LOAD  = 2'd0;
   localparam logic [1:0] MODE_BUILD = 2'd1;
   localparam logic [1:0] MODE_READ  = 2'd2;

   localparam logic [CSR_INDEX_W-1:0] CSR_NFA_STATE_COUNT = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_SYMBOL_COUNT    = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_ACCEPTING_MASK  = 2'd2;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SEED,
      ST_ROW_RD,
      ST_ROW_WAIT,
      ST_UNION,
      ST_SEARCH,
      ST_READ1,
      ST_READ2
   } state_type;

   typedef struct packed {
      logic                   clr;
      logic                   acc;
      logic [STATE_W-1:0]     state_idx;
      logic [SYM_W-1:0]       sym;
      logic [MASK_W-1:0]      live;
   } nfa_ctrl_type;

   typedef struct packed {
      logic                   sub_we;
      logic [ROW_W-1:0]       sub_waddr;
      logic [MASK_W-1:0]      sub_wdata;
      logic [ROW_W-1:0]       sub_raddr;
      logic                   nxt_we;
      logic [NEXT_ADDR_W-1:0] nxt_waddr;
      logic [ROW_W-1:0]       nxt_wdata;
      logic [NEXT_ADDR_W-1:0] nxt_raddr;
   } row_ctrl_type;

   function automatic logic [3:0] clamp_states(input logic [3:0] v);
      if (v == 4'd0) begin
         return 4'd1;
      end else if (v > 4'(MAX_NFA_STATES)) begin
         return 4'(MAX_NFA_STATES);
      end
      return v;
   endfunction

   function automatic logic [2:0] clamp_symbols(input logic [2:0] v);
      if (v == 3'd0) begin
         return 3'd1;
      end else if (v > 3'(MAX_SYMBOLS)) begin
         return 3'(MAX_SYMBOLS);
      end
      return v;
   endfunction

   function automatic logic [MASK_W-1:0] live_mask(input logic [3:0] n);
      logic [MASK_W-1:0] m;
      for (int i = 0; i < MASK_W; i++) begin
         m[i] = (4'(i) < n);
      end
      return m;
   endfunction

endpackage

FILE: sv/nsc_nfa_unit.sv
// ----------------------------------------------------------------------
// NFA transition table and union accumulator
// Holds the NFA target masks and ORs one member's row per cycle.
// ----------------------------------------------------------------------
module nsc_nfa_unit import nsc_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic                load_we,
   input  logic [STATE_W-1:0]  load_state,
   input  logic [SYM_W-1:0]    load_symbol,
   input  logic [MASK_W-1:0]   load_mask,
   input  nfa_ctrl_type        ctrl,
   output logic [MASK_W-1:0]   union_mask
);

   logic [MASK_W-1:0] table_ff [NFA_TABLE_DEPTH];
   logic [MASK_W-1:0] acc_ff;
   logic [MASK_W-1:0] acc_in;
   logic [MASK_W-1:0] row_sel;

   assign row_sel = table_ff[{ctrl.state_idx, ctrl.sym}];

   always_comb begin
      acc_in = acc_ff;
      if (ctrl.clr) begin
         acc_in = '0;
      end else if (ctrl.acc) begin
         acc_in = acc_ff | row_sel;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NFA_TABLE_DEPTH; i++) begin
            table_ff[i] <= '0;
         end
         acc_ff <= '0;
      end else begin
         if (load_we) begin
            table_ff[{load_state, load_symbol}] <= load_mask;
         end
         acc_ff <= acc_in;
      end
   end

   // Targets beyond the states in use never enter a subset.
   assign union_mask = acc_ff & ctrl.live;

endmodule

FILE: sv/nsc_row_store.sv
// ----------------------------------------------------------------------
// DFA row store
// Subset list and successor memories with registered reads and the
// subset compare used by the list search.
// ----------------------------------------------------------------------
module nsc_row_store import nsc_pkg::*; (
   input  logic                clock,
   input  row_ctrl_type        ctrl,
   input  logic [MASK_W-1:0]   key,
   output logic [MASK_W-1:0]   sub_q,
   output logic [ROW_W-1:0]    nxt_q,
   output logic                hit
);

   logic [MASK_W-1:0] subset_list_ff [MAX_DFA_ROWS];
   logic [ROW_W-1:0]  dfa_next_ff [MAX_DFA_ROWS * MAX_SYMBOLS];
   logic [MASK_W-1:0] sub_q_ff;
   logic [ROW_W-1:0]  nxt_q_ff;

   always_ff @(posedge clock) begin
      if (ctrl.sub_we) begin
         subset_list_ff[ctrl.sub_waddr] <= ctrl.sub_wdata;
      end
      sub_q_ff <= subset_list_ff[ctrl.sub_raddr];
   end

   always_ff @(posedge clock) begin
      if (ctrl.nxt_we) begin
         dfa_next_ff[ctrl.nxt_waddr] <= ctrl.nxt_wdata;
      end
      nxt_q_ff <= dfa_next_ff[ctrl.nxt_raddr];
   end

   assign sub_q = sub_q_ff;
   assign nxt_q = nxt_q_ff;
   assign hit   = (sub_q_ff == key);

endmodule

FILE: sv/nfa_subset_construction.sv
// ----------------------------------------------------------------------
// NFA to DFA subset construction engine
// Sequencer that loads NFA transitions, builds the DFA row list and
// reads back DFA rows.
// ----------------------------------------------------------------------
// A word is taken when start is high and busy is low; its result, if any,
// appears on the rsp_ ports for one cycle with rsp_valid high and must be
// captured then, since the receiver cannot stall. A load word leaves busy
// low and gives no result. A read word of a built row passes through the
// read states ST_READ1 and ST_READ2 before its result; a read of a row that
// was not built gives its zero result with the row count straight from idle.
// A build word runs a sequencer around one shared OR accumulator and one
// read port of the subset list: it seeds the singleton rows, then for every
// row reads it and, per symbol in use, ORs the rows of its members and
// searches the listed rows for the union, and a final row read ends the
// walk. The result of a build appears as busy falls. The subset and successor
// memories are not cleared; reads check only the row index against the built
// rows, so a symbol that the build did not use reads an unwritten successor.
module nfa_subset_construction import nsc_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   output logic                   busy,
   input  logic [1:0]             req_mode,
   input  logic [STATE_W-1:0]     req_from_state,
   input  logic [SYM_W-1:0]       req_symbol,
   input  logic [MASK_W-1:0]      req_target_mask,
   input  logic [ROW_W-1:0]       req_row_index,
   output logic                   rsp_valid,
   output logic [MASK_W-1:0]      rsp_subset_mask,
   output logic [ROW_W-1:0]       rsp_next_row,
   output logic [MASK_W-1:0]      rsp_next_mask,
   output logic                   rsp_accepting,
   output logic [COUNT_W-1:0]     rsp_dfa_count,
   input  logic                   csr_we,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata
);

   state_type           state_ff, state_in;
   logic [3:0]          nfa_state_count_ff;
   logic [2:0]          symbol_count_ff;
   logic [MASK_W-1:0]   accepting_mask_ff;

   logic [COUNT_W-1:0]  cnt_ff, cnt_in;
   logic [COUNT_W-1:0]  r_ff, r_in;
   logic [COUNT_W-1:0]  j_ff, j_in;
   logic [ROW_W-1:0]    jd_ff, jd_in;
   logic                cmp_vld_ff, cmp_vld_in;
   logic [SYM_W-1:0]    k_ff, k_in;
   logic [STATE_W-1:0]  b_ff, b_in;
   logic [MASK_W-1:0]   cur_ff, cur_in;
   logic [ROW_W-1:0]    read_nxt_ff, read_nxt_in;
   logic [COUNT_W-1:0]  row_total_ff, row_total_in;

   logic                rsp_valid_ff, rsp_valid_in;
   logic [MASK_W-1:0]   rsp_subset_ff, rsp_subset_in;
   logic [ROW_W-1:0]    rsp_next_row_ff, rsp_next_row_in;
   logic [MASK_W-1:0]   rsp_next_mask_ff, rsp_next_mask_in;
   logic                rsp_acc_ff, rsp_acc_in;
   logic [COUNT_W-1:0]  rsp_count_ff, rsp_count_in;

   logic [3:0]          n_eff;
   logic [2:0]          s_eff;
   logic [STATE_W-1:0]  n_last;
   logic [SYM_W-1:0]    s_last;
   logic                accept;
   logic                read_in_range;
   logic                issue;
   logic                found;
   logic                step_done;

   nfa_ctrl_type        nc;
   row_ctrl_type        rc;
   logic                load_we;
   logic [MASK_W-1:0]   union_mask;
   logic [MASK_W-1:0]   sub_q;
   logic [ROW_W-1:0]    nxt_q;
   logic                hit;

   assign n_eff  = clamp_states(nfa_state_count_ff);
   assign s_eff  = clamp_symbols(symbol_count_ff);
   assign n_last = STATE_W'(n_eff - 4'd1);
   assign s_last = SYM_W'(s_eff - 3'd1);

   assign busy          = (state_ff != ST_IDLE);
   assign accept        = start && !busy;
   assign load_we       = accept && (req_mode == MODE_LOAD);
   assign read_in_range = ({1'b0, req_row_index} < row_total_ff);

   // List search: one address issued per cycle, compare on the next.
   assign issue     = (j_ff < cnt_ff);
   assign found     = cmp_vld_ff && hit;
   assign step_done = found || !issue;

   nsc_nfa_unit u_nfa (
      .clock       (clock),
      .reset       (reset),
      .load_we     (load_we),
      .load_state  (req_from_state),
      .load_symbol (req_symbol),
      .load_mask   (req_target_mask),
      .ctrl        (nc),
      .union_mask  (union_mask)
   );

   nsc_row_store u_rows (
      .clock (clock),
      .ctrl  (rc),
      .key   (union_mask),
      .sub_q (sub_q),
      .nxt_q (nxt_q),
      .hit   (hit)
   );

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept && (req_mode == MODE_BUILD)) begin
               state_in = ST_SEED;
            end else if (accept && (req_mode == MODE_READ) && read_in_range) begin
               state_in = ST_READ1;
            end
         end
         ST_SEED: begin
            if (b_ff == n_last) begin
               state_in = ST_ROW_RD;
            end
         end
         ST_ROW_RD: begin
            state_in = (r_ff == cnt_ff) ? ST_IDLE : ST_ROW_WAIT;
         end
         ST_ROW_WAIT: begin
            state_in = ST_UNION;
         end
         ST_UNION: begin
            if (b_ff == n_last) begin
               state_in = ST_SEARCH;
            end
         end
         ST_SEARCH: begin
            if (step_done) begin
               state_in = (k_ff == s_last) ? ST_ROW_RD : ST_UNION;
            end
         end
         ST_READ1: begin
            state_in = ST_READ2;
         end
         ST_READ2: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Datapath and memory control.
   always_comb begin
      cnt_in           = cnt_ff;
      r_in             = r_ff;
      j_in             = j_ff;
      jd_in            = jd_ff;
      cmp_vld_in       = 1'b0;
      k_in             = k_ff;
      b_in             = b_ff;
      cur_in           = cur_ff;
      read_nxt_in      = read_nxt_ff;
      row_total_in     = row_total_ff;
      rsp_valid_in     = 1'b0;
      rsp_subset_in    = rsp_subset_ff;
      rsp_next_row_in  = rsp_next_row_ff;
      rsp_next_mask_in = rsp_next_mask_ff;
      rsp_acc_in       = rsp_acc_ff;
      rsp_count_in     = rsp_count_ff;

      nc.clr       = 1'b0;
      nc.acc       = 1'b0;
      nc.state_idx = b_ff;
      nc.sym       = k_ff;
      nc.live      = live_mask(n_eff);

      rc.sub_we    = 1'b0;
      rc.sub_waddr = cnt_ff[ROW_W-1:0];
      rc.sub_wdata = union_mask;
      rc.sub_raddr = r_ff[ROW_W-1:0];
      rc.nxt_we    = 1'b0;
      rc.nxt_waddr = {r_ff[ROW_W-1:0], k_ff};
      rc.nxt_wdata = '0;
      rc.nxt_raddr = {req_row_index, req_symbol};

      case (state_ff)
         ST_IDLE: begin
            if (accept && (req_mode == MODE_BUILD)) begin
               b_in   = '0;
               cnt_in = '0;
            end else if (accept && (req_mode == MODE_READ)) begin
               rc.sub_raddr = req_row_index;
               if (!read_in_range) begin
                  rsp_valid_in     = 1'b1;
                  rsp_subset_in    = '0;
                  rsp_next_row_in  = '0;
                  rsp_next_mask_in = '0;
                  rsp_acc_in       = 1'b0;
                  rsp_count_in     = row_total_ff;
               end
            end
         end
         ST_SEED: begin
            rc.sub_we    = 1'b1;
            rc.sub_waddr = ROW_W'(b_ff);
            rc.sub_wdata = MASK_W'(1) << b_ff;
            cnt_in       = COUNT_W'(b_ff) + COUNT_W'(1);
            if (b_ff == n_last) begin
               r_in = '0;
            end else begin
               b_in = b_ff + STATE_W'(1);
            end
         end
         ST_ROW_RD: begin
            k_in = '0;
            if (r_ff == cnt_ff) begin
               row_total_in     = cnt_ff;
               rsp_valid_in     = 1'b1;
               rsp_subset_in    = '0;
               rsp_next_row_in  = '0;
               rsp_next_mask_in = '0;
               rsp_acc_in       = 1'b0;
               rsp_count_in     = cnt_ff;
            end
         end
         ST_ROW_WAIT: begin
            cur_in = sub_q;
            b_in   = '0;
            nc.clr = 1'b1;
         end
         ST_UNION: begin
            nc.acc = cur_ff[b_ff];
            if (b_ff == n_last) begin
               j_in = '0;
            end else begin
               b_in = b_ff + STATE_W'(1);
            end
         end
         ST_SEARCH: begin
            if (issue) begin
               rc.sub_raddr = j_ff[ROW_W-1:0];
               j_in         = j_ff + COUNT_W'(1);
               jd_in        = j_ff[ROW_W-1:0];
               cmp_vld_in   = 1'b1;
            end
            if (step_done) begin
               cmp_vld_in = 1'b0;
               rc.nxt_we  = 1'b1;
               if (found) begin
                  rc.nxt_wdata = jd_ff;
               end else if (!cnt_ff[COUNT_W-1]) begin
                  // New subset: append it as the next row.
                  rc.sub_we    = 1'b1;
                  rc.nxt_wdata = cnt_ff[ROW_W-1:0];
                  cnt_in       = cnt_ff + COUNT_W'(1);
               end else begin
                  // List full: the successor falls back to row zero.
                  rc.nxt_wdata = '0;
               end
               b_in   = '0;
               nc.clr = 1'b1;
               if (k_ff == s_last) begin
                  r_in = r_ff + COUNT_W'(1);
               end else begin
                  k_in = k_ff + SYM_W'(1);
               end
            end
         end
         ST_READ1: begin
            cur_in       = sub_q;
            read_nxt_in  = nxt_q;
            rc.sub_raddr = nxt_q;
         end
         ST_READ2: begin
            rsp_valid_in     = 1'b1;
            rsp_subset_in    = cur_ff;
            rsp_next_row_in  = read_nxt_ff;
            rsp_next_mask_in = sub_q;
            rsp_acc_in       = |(cur_ff & accepting_mask_ff);
            rsp_count_in     = row_total_ff;
         end
         default: begin
            cmp_vld_in = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff           <= ST_IDLE;
         nfa_state_count_ff <= 4'(MAX_NFA_STATES);
         symbol_count_ff    <= 3'd2;
         accepting_mask_ff  <= '0;
         row_total_ff       <= '0;
         cnt_ff             <= '0;
         r_ff               <= '0;
         j_ff               <= '0;
         k_ff               <= '0;
         b_ff               <= '0;
         cmp_vld_ff         <= 1'b0;
         rsp_valid_ff       <= 1'b0;
      end else begin
         state_ff     <= state_in;
         row_total_ff <= row_total_in;
         cnt_ff       <= cnt_in;
         r_ff         <= r_in;
         j_ff         <= j_in;
         k_ff         <= k_in;
         b_ff         <= b_in;
         cmp_vld_ff   <= cmp_vld_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_we) begin
            case (csr_index)
               CSR_NFA_STATE_COUNT: nfa_state_count_ff <= csr_wdata[3:0];
               CSR_SYMBOL_COUNT:    symbol_count_ff    <= csr_wdata[2:0];
               CSR_ACCEPTING_MASK:  accepting_mask_ff  <= csr_wdata;
               default: begin
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      jd_ff            <= jd_in;
      cur_ff           <= cur_in;
      read_nxt_ff      <= read_nxt_in;
      rsp_subset_ff    <= rsp_subset_in;
      rsp_next_row_ff  <= rsp_next_row_in;
      rsp_next_mask_ff <= rsp_next_mask_in;
      rsp_acc_ff       <= rsp_acc_in;
      rsp_count_ff     <= rsp_count_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_subset_mask = rsp_subset_ff;
   assign rsp_next_row    = rsp_next_row_ff;
   assign rsp_next_mask   = rsp_next_mask_ff;
   assign rsp_accepting   = rsp_acc_ff;
   assign rsp_dfa_count   = rsp_count_ff;

   // The row list never grows past its capacity.
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= COUNT_W'(MAX_DFA_ROWS))
      else $error("row count exceeds list capacity");

   // The row walk never passes the end of the list.
   a_walk_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_UNION || state_ff == ST_SEARCH || state_ff == ST_ROW_WAIT)
      |-> (r_ff < cnt_ff))
      else $error("row walk beyond list end");

   // A load word finishes at once and gives no result.
   a_load_quiet: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_mode == MODE_LOAD) |=> (!busy && !rsp_valid))
      else $error("load word started work or gave a result");

   // An accepting row always has a nonempty subset.
   a_accept_subset: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_accepting) |-> (rsp_subset_mask != '0))
      else $error("accepting flag on empty subset");

endmodule

FILE: tb/nfa_subset_construction_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------
// NFA subset construction testbench
// Drives load, build, read and unused words through the command port,
// predicts every result with a behavioral copy of the engine and checks
// each strobed result field by field against the oldest prediction.
// ----------------------------------------------------------------------
module nfa_subset_construction_tb;
   import nsc_pkg::*;

   localparam logic [1:0] MODE_UNUSED   = 2'd3;
   localparam int         PHASES        = 7;
   localparam int         DRAIN_CYCLES  = 16;
   localparam int         SETTLE_CYCLES = 8;

   typedef struct packed {
      logic [MASK_W-1:0]  subset_mask;
      logic [ROW_W-1:0]   next_row;
      logic [MASK_W-1:0]  next_mask;
      logic               accepting;
      logic [COUNT_W-1:0] dfa_count;
   } row_reply_type;

   // A directed word; when fixed is set the result is all zero but for
   // the row count given here.
   typedef struct packed {
      logic [1:0]         mode;
      logic [STATE_W-1:0] from_state;
      logic [SYM_W-1:0]   symbol;
      logic [MASK_W-1:0]  target_mask;
      logic [ROW_W-1:0]   row_index;
      logic               fixed;
      logic [COUNT_W-1:0] fixed_count;
   } word_vec_type;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   start = 1'b0;
   logic                   busy;
   logic [1:0]             req_mode = MODE_LOAD;
   logic [STATE_W-1:0]     req_from_state = '0;
   logic [SYM_W-1:0]       req_symbol = '0;
   logic [MASK_W-1:0]      req_target_mask = '0;
   logic [ROW_W-1:0]       req_row_index = '0;
   logic                   rsp_valid;
   logic [MASK_W-1:0]      rsp_subset_mask;
   logic [ROW_W-1:0]       rsp_next_row;
   logic [MASK_W-1:0]      rsp_next_mask;
   logic                   rsp_accepting;
   logic [COUNT_W-1:0]     rsp_dfa_count;
   logic                   csr_we = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index = CSR_NFA_STATE_COUNT;
   logic [CSR_DATA_W-1:0]  csr_wdata = '0;

   // Behavioral copy of the engine.
   logic [3:0]        cfg_states = 4'd8;
   logic [2:0]        cfg_symbols = 3'd2;
   logic [MASK_W-1:0] cfg_accept = '0;
   logic [MASK_W-1:0] nfa_rows [NFA_TABLE_DEPTH];
   logic [MASK_W-1:0] dfa_subsets [MAX_DFA_ROWS];
   logic [ROW_W-1:0]  dfa_succ [MAX_DFA_ROWS*MAX_SYMBOLS];
   bit                succ_written [MAX_DFA_ROWS*MAX_SYMBOLS];
   int                rows_found = 0;
   int                built_syms = 1;

   row_reply_type reply_q [$];
   word_vec_type  directed_q [$];
   int            error_count = 0;

   int phase_states [PHASES] = '{1, 3, 0, 4, 15, 5, 2};
   int phase_syms   [PHASES] = '{1, 4, 0, 2, 7, 3, 4};
   int phase_accept [PHASES] = '{255, 5, 0, 170, 128, 60, 129};
   int phase_seqs   [PHASES] = '{2, 3, 2, 3, 1, 2, 2};

   nfa_subset_construction i_dut (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_mode        (req_mode),
      .req_from_state  (req_from_state),
      .req_symbol      (req_symbol),
      .req_target_mask (req_target_mask),
      .req_row_index   (req_row_index),
      .rsp_valid       (rsp_valid),
      .rsp_subset_mask (rsp_subset_mask),
      .rsp_next_row    (rsp_next_row),
      .rsp_next_mask   (rsp_next_mask),
      .rsp_accepting   (rsp_accepting),
      .rsp_dfa_count   (rsp_dfa_count),
      .csr_we          (csr_we),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata)
   );

   always #5 clock = ~clock;

   initial begin
      for (int i = 0; i < NFA_TABLE_DEPTH; i++) begin
         nfa_rows[i] = '0;
      end
      for (int i = 0; i < MAX_DFA_ROWS; i++) begin
         dfa_subsets[i] = '0;
      end
      for (int i = 0; i < MAX_DFA_ROWS*MAX_SYMBOLS; i++) begin
         dfa_succ[i] = '0;
         succ_written[i] = 1'b0;
      end
   end

   function automatic int clamp_count(input int v, input int hi);
      if (v < 1) begin
         return 1;
      end else if (v > hi) begin
         return hi;
      end
      return v;
   endfunction

   function automatic int idle_burst(input bit on);
      if (on && $urandom_range(0, 3) == 0) begin
         return $urandom_range(1, 8);
      end
      return 0;
   endfunction

   task automatic add_directed(input word_vec_type v);
      directed_q = {directed_q, v};
   endtask

   // Subset construction over the current NFA table: singleton rows first,
   // then each row's successors in order, appending subsets not yet listed.
   task automatic run_subset_build();
      int                n;
      int                s;
      int                count;
      int                nxt;
      bit                found;
      logic [MASK_W-1:0] live;
      logic [MASK_W-1:0] m;
      n = clamp_count(int'(cfg_states), MAX_NFA_STATES);
      s = clamp_count(int'(cfg_symbols), MAX_SYMBOLS);
      live = MASK_W'((1 << n) - 1);
      count = 0;
      for (int b = 0; b < n && count < MAX_DFA_ROWS; b++) begin
         dfa_subsets[count] = MASK_W'(1 << b);
         count++;
      end
      for (int r = 0; r < count; r++) begin
         for (int k = 0; k < s; k++) begin
            m = '0;
            for (int b = 0; b < n; b++) begin
               if (dfa_subsets[r][b]) begin
                  m |= nfa_rows[b*MAX_SYMBOLS + k];
               end
            end
            m &= live;
            found = 1'b0;
            nxt = 0;
            for (int j = 0; j < count && !found; j++) begin
               if (dfa_subsets[j] == m) begin
                  nxt = j;
                  found = 1'b1;
               end
            end
            // With the list full a new subset is dropped and points at row 0.
            if (!found && count < MAX_DFA_ROWS) begin
               dfa_subsets[count] = m;
               nxt = count;
               count++;
            end
            dfa_succ[r*MAX_SYMBOLS + k] = ROW_W'(nxt);
            succ_written[r*MAX_SYMBOLS + k] = 1'b1;
         end
      end
      rows_found = count;
      built_syms = s;
   endtask

   task automatic predict_word(input logic [1:0] mode, input logic [STATE_W-1:0] from_state,
                               input logic [SYM_W-1:0] symbol,
                               input logic [MASK_W-1:0] target_mask,
                               input logic [ROW_W-1:0] row_index,
                               output bit has_reply, output row_reply_type reply);
      logic [ROW_W-1:0] nxt;
      reply = '0;
      has_reply = 1'b0;
      case (mode)
         MODE_LOAD: begin
            nfa_rows[{from_state, symbol}] = target_mask;
         end
         MODE_BUILD: begin
            run_subset_build();
            has_reply = 1'b1;
         end
         MODE_READ: begin
            has_reply = 1'b1;
            if (int'(row_index) < rows_found) begin
               nxt = dfa_succ[{row_index, symbol}];
               reply.subset_mask = dfa_subsets[row_index];
               reply.next_row    = nxt;
               reply.next_mask   = dfa_subsets[nxt];
               reply.accepting   = (dfa_subsets[row_index] & cfg_accept) != '0;
            end
         end
         default: begin
         end
      endcase
      if (has_reply) begin
         reply.dfa_count = COUNT_W'(rows_found);
      end
   endtask

   // Presents one word, holds it until taken, then records its prediction.
   task automatic send_word(input int gap, input logic [1:0] mode,
                            input logic [STATE_W-1:0] from_state,
                            input logic [SYM_W-1:0] symbol,
                            input logic [MASK_W-1:0] target_mask,
                            input logic [ROW_W-1:0] row_index,
                            input bit fixed, input logic [COUNT_W-1:0] fixed_count);
      bit            has_reply;
      row_reply_type reply;
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start           <= 1'b1;
      req_mode        <= mode;
      req_from_state  <= from_state;
      req_symbol      <= symbol;
      req_target_mask <= target_mask;
      req_row_index   <= row_index;
      do @(posedge clock); while (busy);
      predict_word(mode, from_state, symbol, target_mask, row_index, has_reply, reply);
      if (has_reply) begin
         if (fixed) begin
            reply = '{'0, '0, '0, 1'b0, fixed_count};
         end
         reply_q = {reply_q, reply};
      end
   endtask

   task automatic wait_idle();
      start <= 1'b0;
      while (reply_q.size() != 0 || busy) @(posedge clock);
      // A load leaves no result behind, so give it time to retire.
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic apply_settings(input int states, input int syms, input int accept);
      csr_we    <= 1'b1;
      csr_index <= CSR_NFA_STATE_COUNT;
      csr_wdata <= CSR_DATA_W'(states);
      @(posedge clock);
      cfg_states = 4'(states);
      csr_index <= CSR_SYMBOL_COUNT;
      csr_wdata <= CSR_DATA_W'(syms);
      @(posedge clock);
      cfg_symbols = 3'(syms);
      csr_index <= CSR_ACCEPTING_MASK;
      csr_wdata <= CSR_DATA_W'(accept);
      @(posedge clock);
      cfg_accept = MASK_W'(accept);
      csr_we <= 1'b0;
   endtask

   always @(posedge clock) begin : rsp_check
      row_reply_type want;
      if (!reset && rsp_valid) begin
         if (reply_q.size() == 0) begin
            $error("unexpected result word: dfa_count %0d", rsp_dfa_count);
            error_count++;
         end else begin
            want = reply_q.pop_front();
            if (rsp_subset_mask !== want.subset_mask) begin
               $error("subset_mask: expected %0h, got %0h", want.subset_mask, rsp_subset_mask);
               error_count++;
            end
            if (rsp_next_row !== want.next_row) begin
               $error("next_row: expected %0d, got %0d", want.next_row, rsp_next_row);
               error_count++;
            end
            if (rsp_next_mask !== want.next_mask) begin
               $error("next_mask: expected %0h, got %0h", want.next_mask, rsp_next_mask);
               error_count++;
            end
            if (rsp_accepting !== want.accepting) begin
               $error("accepting: expected %0d, got %0d", want.accepting, rsp_accepting);
               error_count++;
            end
            if (rsp_dfa_count !== want.dfa_count) begin
               $error("dfa_count: expected %0d, got %0d", want.dfa_count, rsp_dfa_count);
               error_count++;
            end
         end
      end
   end

   initial begin
      #(250_000_000);
      $display("** nfa_subset_construction: FAILED **");
      $finish;
   end

   initial begin
      int               n_eff;
      int               s_eff;
      int               loads;
      int               total;
      int               row;
      int               sym;
      bit               idling;
      bit               do_build;
      logic [1:0]       mode;
      logic [STATE_W-1:0] from_state;
      word_vec_type     v;

      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed words, run with the reset settings: eight states, two symbols.
      add_directed('{MODE_READ, 3'd0, 2'd0, 8'h00, 8'h00, 1'b1, 9'd0});
      add_directed('{MODE_READ, 3'd7, 2'd3, 8'hFF, 8'hFF, 1'b1, 9'd0});
      add_directed('{MODE_UNUSED, 3'd7, 2'd3, 8'hFF, 8'hFF, 1'b0, 9'd0});
      // An all-dead table gives the eight singletons plus the dead row.
      add_directed('{MODE_BUILD, 3'd0, 2'd0, 8'h00, 8'h00, 1'b1, 9'd9});
      add_directed('{MODE_READ, 3'd0, 2'd0, 8'h00, 8'h00, 1'b0, 9'd0});
      add_directed('{MODE_READ, 3'd0, 2'd1, 8'h00, 8'd8, 1'b0, 9'd0});
      add_directed('{MODE_READ, 3'd0, 2'd0, 8'h00, 8'd9, 1'b1, 9'd9});
      // Symbol 0 shifts every state up by one and drops the top state;
      // symbol 1 adds state 0. Together they reach all 256 subsets.
      for (int b = 0; b < MAX_NFA_STATES; b++) begin
         add_directed('{MODE_LOAD, 3'(b), 2'd0, 8'((1 << (b + 1)) & 8'hFF), 8'h00,
                        1'b0, 9'd0});
         add_directed('{MODE_LOAD, 3'(b), 2'd1, 8'((1 << b) | 1), 8'h00,
                        1'b0, 9'd0});
      end
      add_directed('{MODE_BUILD, 3'd0, 2'd0, 8'h00, 8'h00, 1'b1, 9'd256});
      add_directed('{MODE_READ, 3'd0, 2'd1, 8'h00, 8'd255, 1'b0, 9'd0});
      add_directed('{MODE_READ, 3'd0, 2'd0, 8'h00, 8'd128, 1'b0, 9'd0});
      foreach (directed_q[i]) begin
         v = directed_q[i];
         send_word(idle_burst(1'b1), v.mode, v.from_state, v.symbol, v.target_mask,
                   v.row_index, v.fixed, v.fixed_count);
      end

      // Random part: per setting, runs of loads, a build and reads of the
      // rows it made; some runs skip the build and read stale rows.
      for (int p = 0; p < PHASES; p++) begin
         wait_idle();
         apply_settings(phase_states[p], phase_syms[p], phase_accept[p]);
         n_eff = clamp_count(phase_states[p], MAX_NFA_STATES);
         s_eff = clamp_count(phase_syms[p], MAX_SYMBOLS);
         idling = (p != PHASES - 1);
         for (int q = 0; q < phase_seqs[p]; q++) begin
            loads = $urandom_range(1, 6);
            do_build = ($urandom_range(0, 4) != 0);
            total = loads + int'(do_build) + $urandom_range(2, 4);
            for (int i = 0; i < total; i++) begin
               if ($urandom_range(0, 11) == 0) begin
                  send_word(idle_burst(idling), MODE_UNUSED, 3'($urandom), 2'($urandom),
                            8'($urandom), 8'($urandom), 1'b0, 9'd0);
               end
               if (i < loads) begin
                  mode = MODE_LOAD;
               end else if (i == loads && do_build) begin
                  mode = MODE_BUILD;
               end else begin
                  mode = MODE_READ;
               end
               from_state = ($urandom_range(0, 9) < 7) ? 3'($urandom_range(0, n_eff - 1))
                                                        : 3'($urandom_range(0, 7));
               sym = ($urandom_range(0, 9) < 7 || mode != MODE_LOAD)
                     ? $urandom_range(0, s_eff - 1) : $urandom_range(0, 3);
               row = $urandom_range(0, 255);
               if (mode == MODE_READ) begin
                  sym = $urandom_range(0, 3);
                  if (rows_found > 0 && $urandom_range(0, 3) != 0) begin
                     row = $urandom_range(0, rows_found - 1);
                  end
                  // Never ask for a successor that no build has written.
                  if (row < rows_found && !succ_written[row*MAX_SYMBOLS + sym]) begin
                     sym = $urandom_range(0, built_syms - 1);
                  end
               end
               send_word(idle_burst(idling), mode, from_state, 2'(sym), 8'($urandom),
                         8'(row), 1'b0, 9'd0);
            end
         end
      end

      start <= 1'b0;
      while (reply_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0) begin
         $display("** nfa_subset_construction: PASSED **");
      end else begin
         $display("** nfa_subset_construction: FAILED **");
      end
      $finish;
   end

endmodule
